FILE: src/cbz_pkg.sv
`default_nettype none

package cbz_pkg;

    // Fixed point format of all curve arithmetic.
    localparam int FRAC_BITS = 16;

    // Screen coordinate widths.
    localparam int X_W = 7;
    localparam int Y_W = 6;

    // Pipeline depth of one interpolation unit and of the three de Casteljau levels.
    localparam int LERP_LAT = 4;
    localparam int EVAL_LAT = 3 * LERP_LAT;

    // Curve queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_point;

    typedef struct packed {
        t_point p1;
        t_point p2;
        t_point p3;
        t_point p4;
    } t_curve;

    // Control that travels with each step through the evaluation pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_step_ctl;

endpackage

`default_nettype wire

FILE: src/cbz_lerp.sv
`default_nettype none

// One interpolation floor((a*i + b*(S-i)) / S), four register stages.
// The division by S is a multiply by a truncated reciprocal followed by
// a single remainder correction.
module cbz_lerp #(
    parameter int SEGMENTS = 60,
    parameter int VW       = 23,
    parameter int SW       = $clog2(SEGMENTS + 1)
) (
    input  wire           i_clk,
    input  wire           i_en,
    input  wire  [VW-1:0] i_a,
    input  wire  [VW-1:0] i_b,
    input  wire  [SW-1:0] i_step,
    output logic [VW-1:0] o_q
);

    localparam int XW = VW + SW;
    localparam int RW = XW + 1;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << XW) / SEGMENTS);
    localparam logic [SW-1:0] SEG   = SW'(SEGMENTS);
    localparam logic [XW-1:0] SEG_X = XW'(SEGMENTS);
    localparam logic [SW:0]   SEG_R = (SW + 1)'(SEGMENTS);

    logic [XW-1:0]    n_ta;
    logic [XW-1:0]    n_tb;
    logic [XW+RW-1:0] n_prod;
    logic [XW-1:0]    n_diff;
    logic [XW-1:0]    r_sum;
    logic [XW-1:0]    r_sum_d;
    logic [VW-1:0]    r_q0;
    logic [VW-1:0]    r_q0_d;
    logic [SW:0]      r_rem;
    logic [VW-1:0]    r_q;

    // Weighted sum of the two end values, then the reciprocal product.
    always_comb begin
        n_ta   = XW'(i_a) * XW'(i_step);
        n_tb   = XW'(i_b) * XW'(SEG - i_step);
        n_prod = {{RW{1'b0}}, r_sum} * {{XW{1'b0}}, RECIP};
        n_diff = r_sum_d - XW'(r_q0) * SEG_X;
    end

    // The estimate is exact or one low; the remainder tells which.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= n_ta + n_tb;
            r_q0    <= n_prod[XW +: VW];
            r_sum_d <= r_sum;
            r_rem   <= n_diff[SW:0];
            r_q0_d  <= r_q0;
            r_q     <= (r_rem >= SEG_R) ? r_q0_d + VW'(1) : r_q0_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

FILE: src/cbz_eval.sv
`default_nettype none

// De Casteljau evaluation of one coordinate: three levels of interpolation
// units, with the step index delayed alongside each level.
module cbz_eval #(
    parameter int SEGMENTS = 60,
    parameter int W        = 7,
    parameter int SW       = $clog2(SEGMENTS + 1)
) (
    input  wire          i_clk,
    input  wire          i_en,
    input  wire [SW-1:0] i_step,
    input  wire [W-1:0]  i_p1,
    input  wire [W-1:0]  i_p2,
    input  wire [W-1:0]  i_p3,
    input  wire [W-1:0]  i_p4,
    output logic [W-1:0] o_pt
);

    import cbz_pkg::*;

    localparam int VW = W + FRAC_BITS;

    logic [VW-1:0] c1, c2, c3, c4;
    logic [VW-1:0] a1, a2, a3, b1, b2, q;
    logic [SW-1:0] r_step_l2 [LERP_LAT];
    logic [SW-1:0] r_step_l3 [LERP_LAT];

    // Control points move into fixed point.
    assign c1 = {i_p1, {FRAC_BITS{1'b0}}};
    assign c2 = {i_p2, {FRAC_BITS{1'b0}}};
    assign c3 = {i_p3, {FRAC_BITS{1'b0}}};
    assign c4 = {i_p4, {FRAC_BITS{1'b0}}};

    // Step index delay lines that match the latency of each level.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_step_l2[0] <= i_step;
            r_step_l3[0] <= r_step_l2[LERP_LAT-1];
            for (int k = 1; k < LERP_LAT; k++) begin
                r_step_l2[k] <= r_step_l2[k-1];
                r_step_l3[k] <= r_step_l3[k-1];
            end
        end
    end

    // First level.
    cbz_lerp #(.SEGMENTS(SEGMENTS), .VW(VW), .SW(SW)) u_a1 (
        .i_clk(i_clk), .i_en(i_en), .i_a(c1), .i_b(c2), .i_step(i_step), .o_q(a1)
    );
    cbz_lerp #(.SEGMENTS(SEGMENTS), .VW(VW), .SW(SW)) u_a2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(c2), .i_b(c3), .i_step(i_step), .o_q(a2)
    );
    cbz_lerp #(.SEGMENTS(SEGMENTS), .VW(VW), .SW(SW)) u_a3 (
        .i_clk(i_clk), .i_en(i_en), .i_a(c3), .i_b(c4), .i_step(i_step), .o_q(a3)
    );

    // Second level.
    cbz_lerp #(.SEGMENTS(SEGMENTS), .VW(VW), .SW(SW)) u_b1 (
        .i_clk(i_clk), .i_en(i_en), .i_a(a1), .i_b(a2),
        .i_step(r_step_l2[LERP_LAT-1]), .o_q(b1)
    );
    cbz_lerp #(.SEGMENTS(SEGMENTS), .VW(VW), .SW(SW)) u_b2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(a2), .i_b(a3),
        .i_step(r_step_l2[LERP_LAT-1]), .o_q(b2)
    );

    // Final level.
    cbz_lerp #(.SEGMENTS(SEGMENTS), .VW(VW), .SW(SW)) u_c (
        .i_clk(i_clk), .i_en(i_en), .i_a(b1), .i_b(b2),
        .i_step(r_step_l3[LERP_LAT-1]), .o_q(q)
    );

    // Integer part of the curve point.
    assign o_pt = q[VW-1:FRAC_BITS];

endmodule

`default_nettype wire

FILE: src/cbz_front.sv
`default_nettype none

// Front end: takes curves in and holds them in a short queue until the
// back end has issued all of their steps.
module cbz_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  cbz_pkg::t_curve i_curve,
    input  wire                   i_pop,
    output logic                  o_head_valid,
    output cbz_pkg::t_curve       o_head
);

    import cbz_pkg::*;

    t_curve            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              push;

    assign o_in_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Occupancy follows the push and pop transfers.
    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_curve;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("curve queue count beyond its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("curve queue popped while empty");
`endif

endmodule

`default_nettype wire

FILE: src/cbz_seq.sv
`default_nettype none

// Back end step sequencer: issues steps 1 to SEGMENTS of the curve at the
// queue head, one per enabled cycle, and releases the curve on the last.
module cbz_seq #(
    parameter int SEGMENTS = 60,
    parameter int SW       = $clog2(SEGMENTS + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_head_valid,
    output logic                o_pop,
    output logic [SW-1:0]       o_step,
    output cbz_pkg::t_step_ctl  o_ctl
);

    import cbz_pkg::*;

    localparam logic [SW-1:0] SEG = SW'(SEGMENTS);

    logic [SW-1:0] r_step;
    logic [SW-1:0] n_step;

    // Step flags for the evaluation pipeline.
    always_comb begin
        o_ctl.valid = i_head_valid;
        o_ctl.first = (r_step == SW'(1));
        o_ctl.last  = (r_step == SEG);
    end

    assign o_step = r_step;
    assign o_pop  = i_en && i_head_valid && o_ctl.last;

    // Advance the step on each issue, wrap after the last one.
    always_comb begin
        n_step = r_step;
        if (i_en && i_head_valid) begin
            n_step = o_ctl.last ? SW'(1) : r_step + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SW'(1);
        end else begin
            r_step <= n_step;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step >= SW'(1)) && (r_step <= SEG))
        else $error("step index out of range");
`endif

endmodule

`default_nettype wire

FILE: src/cubic_bezier_segment_generator.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_pt1_x .. i_pt4_y (one curve)
// out       output     o_out_valid / i_out_ready  o_seg_start_*, o_seg_end_*, o_last_segment
//
// Each curve gives SEGMENTS segments, one per cycle while the output is not
// stalled; the step sequencer issues one step per enabled cycle.
// Each step passes through the evaluation pipeline and then the output register.
// Reset empties the curve queue, sets the step counter to 1 and clears the pipeline valid bits.
// A stalled output freezes the evaluation pipeline; the queue still takes up
// to two curves.
module cubic_bezier_segment_generator #(
    parameter int SEGMENTS = 60
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [6:0]  i_pt1_x,
    input  wire  [5:0]  i_pt1_y,
    input  wire  [6:0]  i_pt2_x,
    input  wire  [5:0]  i_pt2_y,
    input  wire  [6:0]  i_pt3_x,
    input  wire  [5:0]  i_pt3_y,
    input  wire  [6:0]  i_pt4_x,
    input  wire  [5:0]  i_pt4_y,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [6:0]  o_seg_start_x,
    output logic [5:0]  o_seg_start_y,
    output logic [6:0]  o_seg_end_x,
    output logic [5:0]  o_seg_end_y,
    output logic        o_last_segment
);

    import cbz_pkg::*;

    localparam int SW = $clog2(SEGMENTS + 1);

    t_curve     in_curve;
    t_curve     head;
    logic       head_valid;
    logic       pop;
    logic       en;
    logic [SW-1:0] step;
    t_step_ctl  issue_ctl;
    t_step_ctl  r_ctl_pipe [EVAL_LAT];
    t_point     r_p4_pipe  [EVAL_LAT];
    t_step_ctl  pipe_ctl;
    t_point     pipe_p4;
    logic [X_W-1:0] end_x;
    logic [Y_W-1:0] end_y;
    logic       r_out_valid;
    logic [X_W-1:0] r_start_x;
    logic [Y_W-1:0] r_start_y;
    logic [X_W-1:0] r_end_x;
    logic [Y_W-1:0] r_end_y;
    logic       r_last;

    always_comb begin
        in_curve.p1.x = i_pt1_x;
        in_curve.p1.y = i_pt1_y;
        in_curve.p2.x = i_pt2_x;
        in_curve.p2.y = i_pt2_y;
        in_curve.p3.x = i_pt3_x;
        in_curve.p3.y = i_pt3_y;
        in_curve.p4.x = i_pt4_x;
        in_curve.p4.y = i_pt4_y;
    end

    // The whole back end moves when the output register can take a segment.
    assign en = !r_out_valid || i_out_ready;

    cbz_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_curve      (in_curve),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    cbz_seq #(.SEGMENTS(SEGMENTS), .SW(SW)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_step       (step),
        .o_ctl        (issue_ctl)
    );

    cbz_eval #(.SEGMENTS(SEGMENTS), .W(X_W), .SW(SW)) u_eval_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_step (step),
        .i_p1   (head.p1.x),
        .i_p2   (head.p2.x),
        .i_p3   (head.p3.x),
        .i_p4   (head.p4.x),
        .o_pt   (end_x)
    );

    cbz_eval #(.SEGMENTS(SEGMENTS), .W(Y_W), .SW(SW)) u_eval_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_step (step),
        .i_p1   (head.p1.y),
        .i_p2   (head.p2.y),
        .i_p3   (head.p3.y),
        .i_p4   (head.p4.y),
        .o_pt   (end_y)
    );

    // Step control delay line, matched to the evaluation latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EVAL_LAT; k++) begin
                r_ctl_pipe[k] <= '0;
            end
        end else if (en) begin
            r_ctl_pipe[0] <= issue_ctl;
            for (int k = 1; k < EVAL_LAT; k++) begin
                r_ctl_pipe[k] <= r_ctl_pipe[k-1];
            end
        end
    end

    // Start point of the first segment travels with the step.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_pipe[0] <= head.p4;
            for (int k = 1; k < EVAL_LAT; k++) begin
                r_p4_pipe[k] <= r_p4_pipe[k-1];
            end
        end
    end

    assign pipe_ctl = r_ctl_pipe[EVAL_LAT-1];
    assign pipe_p4  = r_p4_pipe[EVAL_LAT-1];

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= pipe_ctl.valid;
        end
    end

    // Segment payload; the start is the end of the segment loaded before, or P4 for the first segment of a curve.
    always_ff @(posedge i_clk) begin
        if (en && pipe_ctl.valid) begin
            r_start_x <= pipe_ctl.first ? pipe_p4.x : r_end_x;
            r_start_y <= pipe_ctl.first ? pipe_p4.y : r_end_y;
            r_end_x   <= end_x;
            r_end_y   <= end_y;
            r_last    <= pipe_ctl.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_seg_start_x  = r_start_x;
    assign o_seg_start_y  = r_start_y;
    assign o_seg_end_x    = r_end_x;
    assign o_seg_end_y    = r_end_y;
    assign o_last_segment = r_last;

`ifndef NO_ASSERTIONS
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_segment) |=>
        (!o_out_valid || ((o_seg_start_x == $past(o_seg_end_x)) &&
                          (o_seg_start_y == $past(o_seg_end_y)))))
        else $error("segment does not start at the previous segment end");
`endif

endmodule

`default_nettype wire
